[sv/tti_pkg.sv]
// Shared types, constants and helpers for the trajectory time interpolator.
// No dependencies; the core, divider, sequencer, datapath and testbench import it.
`default_nettype none
package tti_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int MU_BITS     = 24;
  localparam int DIV_N       = 64;
  localparam int DIV_CNT_W   = $clog2(DIV_N);

  localparam logic signed [17:0] YAW_PI     = 18'sd25736;
  localparam logic signed [17:0] YAW_TWO_PI = 18'sd51472;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] yaw;
    logic [31:0] t;
  } pose_t;

  typedef enum logic [2:0] {
    RD_LAST, RD_ZERO, RD_MID, RD_PREV, RD_CUR
  } rd_sel_t;

  typedef enum logic [1:0] {
    DS_MU, DS_VX, DS_VY, DS_VYAW
  } div_sel_t;

  typedef enum logic [1:0] {
    EM_ZERO, EM_POSE, EM_INTERP
  } emit_kind_t;

  typedef struct packed {
    logic       in_ready;
    logic       rd_en;
    rd_sel_t    rd_sel;
    logic       cap0;
    logic       cap1;
    logic       srch_init;
    logic       srch_step;
    logic       div_start;
    div_sel_t   div_sel;
    logic       mul_en;
    logic       emit;
    emit_kind_t emit_kind;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_op;
    logic count_zero;
    logic tau_neg;
    logic ge_last;
    logic le_first;
    logic srch_done;
    logic num_le0;
    logic div_busy;
    logic div_done;
    logic out_free;
  } stat_t;

  // Map a heading to [-pi, pi) in Q13; input stays within two turns of range
  function automatic logic signed [15:0] wrap_yaw(input logic signed [17:0] v);
    logic signed [17:0] r;
    r = v;
    for (int k = 0; k < 2; k++) begin
      if (r >= YAW_PI) begin
        r = r - YAW_TWO_PI;
      end else if (r < -YAW_PI) begin
        r = r + YAW_TWO_PI;
      end
    end
    return r[15:0];
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/tti_in_if.sv]
// Input channel: pose writes and time queries with valid/ready handshake.
// No dependencies.
`default_nettype none
interface tti_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [9:0]         entry_index;
  logic signed [31:0] entry_x;
  logic signed [31:0] entry_y;
  logic signed [15:0] entry_yaw;
  logic [31:0]        entry_time;
  logic               last_entry;
  logic [31:0]        query_time;

  modport source (output valid, op, entry_index, entry_x, entry_y, entry_yaw,
                  entry_time, last_entry, query_time, input ready);
  modport sink   (input valid, op, entry_index, entry_x, entry_y, entry_yaw,
                  entry_time, last_entry, query_time, output ready);
endinterface
`default_nettype wire

[sv/tti_out_if.sv]
// Result channel: interpolated pose, velocities and segment index.
// No dependencies.
`default_nettype none
interface tti_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [15:0] out_yaw;
  logic signed [31:0] out_vx;
  logic signed [31:0] out_vy;
  logic signed [31:0] out_vyaw;
  logic [9:0]         segment_index;

  modport source (output valid, out_x, out_y, out_yaw, out_vx, out_vy, out_vyaw,
                  segment_index, input ready);
  modport sink   (input valid, out_x, out_y, out_yaw, out_vx, out_vy, out_vyaw,
                  segment_index, output ready);
endinterface
`default_nettype wire

[sv/trajectory_time_interpolator_core.sv]
// Top level: trajectory time interpolator, sequencer plus datapath.
// Depends on tti_pkg, tti_in_if, tti_out_if, tti_ctrl and tti_dp.
//
//   channel    direction  handshake        payload
//   in_chan    in         valid/ready      op, entry fields, query_time
//   out_chan   out        valid/ready      pose, velocities, segment_index
//   cfg_*      in         cfg_we strobe    start_time (32 bits)
//
// A pose write is taken while the sequencer is idle. A query that clamps
// skips the search; otherwise it runs a binary search on the single table
// read port, then divides mu, multiplies, then divides vx, vy and yaw rate.
// Reset is synchronous active low and empties the table; no clearing pass.
// A stalled result waits in the output register; the block stops only if a
// second result is ready before the first is taken.
`default_nettype none
module trajectory_time_interpolator_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  tti_in_if.sink           in_chan,
  tti_out_if.source        out_chan
);
  import tti_pkg::*;

  cmd_t  cmd;
  stat_t st;

  tti_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd)
  );

  tti_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

endmodule
`default_nettype wire

[sv/tti_div.sv]
// Serial restoring divider, one quotient bit per cycle, unsigned 64 by 32.
// Depends on tti_pkg.
`default_nettype none
module tti_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [63:0]      quotient
);
  import tti_pkg::*;

  logic                 busy_r, done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [31:0]          rem_r, dv_r;
  logic [63:0]          q_r;
  logic [32:0]          trial;
  logic                 fits;

  assign trial = {rem_r, q_r[63]};
  assign fits  = trial >= {1'b0, dv_r};

  // Control: count iterations, pulse done after the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_N - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift dividend out, quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend;
      dv_r  <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? 32'(trial - {1'b0, dv_r}) : trial[31:0];
      q_r   <= {q_r[62:0], fits};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;

endmodule
`default_nettype wire

[sv/tti_ctrl.sv]
// Query sequencer: clamp checks, binary search steps, divide and multiply order.
// Depends on tti_pkg; drives tti_dp through cmd_t and reads stat_t.
`default_nettype none
module tti_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire tti_pkg::stat_t st,
  output tti_pkg::cmd_t       cmd
);
  import tti_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_QST   = 15'b000000000000010,
    S_RDL   = 15'b000000000000100,
    S_CHKL  = 15'b000000000001000,
    S_RD0   = 15'b000000000010000,
    S_CHK0  = 15'b000000000100000,
    S_SRD   = 15'b000000001000000,
    S_SCMP  = 15'b000000010000000,
    S_RDP   = 15'b000000100000000,
    S_RDC   = 15'b000001000000000,
    S_CHKC  = 15'b000010000000000,
    S_DIVS  = 15'b000100000000000,
    S_DIVW  = 15'b001000000000000,
    S_MUL   = 15'b010000000000000,
    S_EMIT  = 15'b100000000000000
  } state_t;

  state_t     state_r, state_nxt;
  div_sel_t   sel_r, sel_nxt;
  emit_kind_t kind_r, kind_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= DS_MU;
      kind_r  <= EM_ZERO;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      kind_r  <= kind_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    kind_nxt      = kind_r;
    cmd           = '0;
    cmd.rd_sel    = RD_ZERO;
    cmd.div_sel   = sel_r;
    cmd.emit_kind = kind_r;
    case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (st.in_valid && st.in_op == OP_QUERY) begin
          state_nxt = S_QST;
        end
      end
      S_QST: begin
        if (st.count_zero) begin
          kind_nxt  = EM_ZERO;
          state_nxt = S_EMIT;
        end else if (st.tau_neg) begin
          state_nxt = S_RD0;
        end else begin
          state_nxt = S_RDL;
        end
      end
      S_RDL: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_LAST;
        state_nxt  = S_CHKL;
      end
      S_CHKL: begin
        cmd.cap0 = 1'b1;
        if (st.ge_last) begin
          kind_nxt  = EM_POSE;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_RD0;
        end
      end
      S_RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_ZERO;
        state_nxt  = S_CHK0;
      end
      S_CHK0: begin
        cmd.cap0 = 1'b1;
        if (st.tau_neg || st.le_first) begin
          kind_nxt  = EM_POSE;
          state_nxt = S_EMIT;
        end else begin
          cmd.srch_init = 1'b1;
          state_nxt     = S_SRD;
        end
      end
      S_SRD: begin
        if (st.srch_done) begin
          state_nxt = S_RDP;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_MID;
          state_nxt  = S_SCMP;
        end
      end
      S_SCMP: begin
        cmd.srch_step = 1'b1;
        state_nxt     = S_SRD;
      end
      S_RDP: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_PREV;
        state_nxt  = S_RDC;
      end
      S_RDC: begin
        cmd.cap0   = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_CUR;
        state_nxt  = S_CHKC;
      end
      S_CHKC: begin
        cmd.cap1 = 1'b1;
        if (st.num_le0) begin
          kind_nxt  = EM_POSE;
          state_nxt = S_EMIT;
        end else begin
          sel_nxt   = DS_MU;
          state_nxt = S_DIVS;
        end
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVW;
      end
      S_DIVW: begin
        if (st.div_done) begin
          case (sel_r)
            DS_MU:   state_nxt = S_MUL;
            DS_VX: begin
              sel_nxt   = DS_VY;
              state_nxt = S_DIVS;
            end
            DS_VY: begin
              sel_nxt   = DS_VYAW;
              state_nxt = S_DIVS;
            end
            default: begin
              kind_nxt  = EM_INTERP;
              state_nxt = S_EMIT;
            end
          endcase
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        sel_nxt    = DS_VX;
        state_nxt  = S_DIVS;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> st.out_free) else $error("result emitted into a full register");
  a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.in_ready && st.in_valid && st.in_op == OP_QUERY) |=> !cmd.in_ready)
    else $error("input taken while a query is running");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !st.div_busy) else $error("divider restarted while busy");
`endif

endmodule
`default_nettype wire

[sv/tti_dp.sv]
// Datapath: pose memory, search bounds, divider, multipliers, output register.
// Depends on tti_pkg, tti_in_if, tti_out_if and tti_div.
`default_nettype none
module tti_dp (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [31:0]   cfg_wdata,
  input  wire tti_pkg::cmd_t cmd,
  output tti_pkg::stat_t     st,
  tti_in_if.sink             in_chan,
  tti_out_if.source          out_chan
);
  import tti_pkg::*;

  pose_t              pose_mem_r [TABLE_DEPTH];
  pose_t              rdata_r, s0_r, s1_r;
  logic [ADDR_W-1:0]  rd_idx_r, s0_idx_r, rd_addr;
  logic [CNT_W-1:0]   count_r, last_c;
  logic [31:0]        start_r;
  logic [32:0]        tau_r;
  logic [ADDR_W-1:0]  lo_r, hi_r, mid;
  logic [ADDR_W:0]    mid_sum;
  logic               accept, wr_ok;

  logic signed [32:0] dx_r, dy_r, dx_c, dy_c;
  logic signed [15:0] dyaw_r, dyaw_c;
  logic [MU_BITS:0]   mu_r;
  logic signed [58:0] px_r, py_r;
  logic signed [42:0] pyaw_r;
  logic [31:0]        vx_r, vy_r, vyaw_r;
  logic [31:0]        num_c, dt_c;
  logic signed [43:0] pv;
  logic [43:0]        pv_mag;
  logic [63:0]        dividend;
  logic               neg_r;
  logic               div_busy, div_done;
  logic [63:0]        quo;
  logic signed [63:0] quo_s;

  logic               out_valid_r;
  logic [31:0]        ox_r, oy_r, ovx_r, ovy_r, ovyaw_r;
  logic [15:0]        oyaw_r;
  logic [9:0]         oseg_r;

  assign accept = in_chan.valid && cmd.in_ready;
  assign wr_ok  = 32'(in_chan.entry_index) < 32'(TABLE_DEPTH);
  assign in_chan.ready = cmd.in_ready;

  // Configuration and table length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      count_r <= '0;
    end else begin
      if (cfg_we) begin
        start_r <= cfg_wdata;
      end
      if (accept && in_chan.op == OP_WRITE && wr_ok && in_chan.last_entry) begin
        count_r <= CNT_W'(in_chan.entry_index) + CNT_W'(1);
      end
    end
  end

  // Capture relative query time
  always_ff @(posedge clk) begin
    if (accept && in_chan.op == OP_QUERY) begin
      tau_r <= {1'b0, in_chan.query_time} - {1'b0, start_r};
    end
  end

  // Read address select
  assign last_c  = count_r - CNT_W'(1);
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[ADDR_W:1];
  always_comb begin
    case (cmd.rd_sel)
      RD_LAST: rd_addr = last_c[ADDR_W-1:0];
      RD_MID:  rd_addr = mid;
      RD_PREV: rd_addr = hi_r - 1'b1;
      RD_CUR:  rd_addr = hi_r;
      default: rd_addr = '0;
    endcase
  end

  // Pose memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && in_chan.op == OP_WRITE && wr_ok) begin
      pose_mem_r[ADDR_W'(in_chan.entry_index)] <= '{x: in_chan.entry_x,
        y: in_chan.entry_y, yaw: in_chan.entry_yaw, t: in_chan.entry_time};
    end
    if (cmd.rd_en) begin
      rdata_r  <= pose_mem_r[rd_addr];
      rd_idx_r <= rd_addr;
    end
  end

  // Hold the two segment end poses
  always_ff @(posedge clk) begin
    if (cmd.cap0) begin
      s0_r     <= rdata_r;
      s0_idx_r <= rd_idx_r;
    end
    if (cmd.cap1) begin
      s1_r <= rdata_r;
    end
  end

  // Advance search bounds
  always_ff @(posedge clk) begin
    if (cmd.srch_init) begin
      lo_r <= ADDR_W'(1);
      hi_r <= last_c[ADDR_W-1:0];
    end else if (cmd.srch_step) begin
      if (rdata_r.t >= tau_r[31:0]) begin
        hi_r <= mid;
      end else begin
        lo_r <= mid + 1'b1;
      end
    end
  end

  // Segment deltas
  assign num_c  = tau_r[31:0] - s0_r.t;
  assign dt_c   = s1_r.t - s0_r.t;
  assign dx_c   = $signed({s1_r.x[31], s1_r.x}) - $signed({s0_r.x[31], s0_r.x});
  assign dy_c   = $signed({s1_r.y[31], s1_r.y}) - $signed({s0_r.y[31], s0_r.y});
  assign dyaw_c = wrap_yaw(18'($signed(s1_r.yaw)) - 18'($signed(s0_r.yaw)));

  // Dividend for the selected division
  always_comb begin
    case (cmd.div_sel)
      DS_VX:   pv = 44'(dx_r) * 44'sd1000;
      DS_VY:   pv = 44'(dy_r) * 44'sd1000;
      default: pv = 44'(dyaw_r) * 44'sd8000;
    endcase
    pv_mag = pv[43] ? 44'(-pv) : pv;
    if (cmd.div_sel == DS_MU) begin
      dividend = {8'd0, num_c, 24'd0};
    end else begin
      dividend = 64'(pv_mag);
    end
  end

  tti_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (dt_c),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo)
  );

  assign quo_s = neg_r ? -$signed(quo) : $signed(quo);

  // Latch deltas, sign, quotients and products
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg_r <= (cmd.div_sel != DS_MU) && pv[43];
      if (cmd.div_sel == DS_MU) begin
        dx_r   <= dx_c;
        dy_r   <= dy_c;
        dyaw_r <= dyaw_c;
      end
    end
    if (div_done) begin
      case (cmd.div_sel)
        DS_MU:   mu_r   <= quo[MU_BITS:0];
        DS_VX:   vx_r   <= sat32(quo_s);
        DS_VY:   vy_r   <= sat32(quo_s);
        default: vyaw_r <= sat32(quo_s);
      endcase
    end
    if (cmd.mul_en) begin
      px_r   <= 59'(dx_r) * 59'($signed({1'b0, mu_r}));
      py_r   <= 59'(dy_r) * 59'($signed({1'b0, mu_r}));
      pyaw_r <= 43'(dyaw_r) * 43'($signed({1'b0, mu_r}));
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.emit_kind)
        EM_POSE: begin
          ox_r    <= s0_r.x;
          oy_r    <= s0_r.y;
          oyaw_r  <= wrap_yaw(18'($signed(s0_r.yaw)));
          ovx_r   <= '0;
          ovy_r   <= '0;
          ovyaw_r <= '0;
          oseg_r  <= 10'(s0_idx_r);
        end
        EM_INTERP: begin
          ox_r    <= s0_r.x + px_r[55:24];
          oy_r    <= s0_r.y + py_r[55:24];
          oyaw_r  <= wrap_yaw(18'($signed(s0_r.yaw)) + $signed(pyaw_r[41:24]));
          ovx_r   <= vx_r;
          ovy_r   <= vy_r;
          ovyaw_r <= vyaw_r;
          oseg_r  <= 10'(s0_idx_r);
        end
        default: begin
          ox_r    <= '0;
          oy_r    <= '0;
          oyaw_r  <= '0;
          ovx_r   <= '0;
          ovy_r   <= '0;
          ovyaw_r <= '0;
          oseg_r  <= '0;
        end
      endcase
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.out_x         = ox_r;
  assign out_chan.out_y         = oy_r;
  assign out_chan.out_yaw       = oyaw_r;
  assign out_chan.out_vx        = ovx_r;
  assign out_chan.out_vy        = ovy_r;
  assign out_chan.out_vyaw      = ovyaw_r;
  assign out_chan.segment_index = oseg_r;

  // Status back to the sequencer
  always_comb begin
    st.in_valid   = in_chan.valid;
    st.in_op      = in_chan.op;
    st.count_zero = count_r == '0;
    st.tau_neg    = tau_r[32];
    st.ge_last    = tau_r[31:0] >= rdata_r.t;
    st.le_first   = tau_r[31:0] <= rdata_r.t;
    st.srch_done  = lo_r >= hi_r;
    st.num_le0    = tau_r[31:0] <= s0_r.t;
    st.div_busy   = div_busy;
    st.div_done   = div_done;
    st.out_free   = !out_valid_r || out_chan.ready;
  end

`ifndef SYNTHESIS
  a_step_open: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.srch_step |-> (lo_r < hi_r)) else $error("search step on a closed range");
  a_mul_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_en |-> !div_busy) else $error("multiply while divider is running");
  a_emit_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.emit_kind == EM_INTERP) |-> !div_busy)
    else $error("interpolated result emitted before divides finished");
`endif

endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for trajectory_time_interpolator_core: random pose tables,
// time queries and start_time settings, checked against a local interpolation model.
// Depends on tti_pkg, tti_in_if, tti_out_if and the core itself.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tti_pkg::*;

  localparam int  WDOG_LIMIT = 6000;
  localparam int  SETTLE     = 24;
  localparam int  HOLD_LEN   = 900;
  localparam int  N_ITEMS    = 1100;
  localparam longint YAW_HALF = 25736;
  localparam longint YAW_TURN = 51472;

  typedef enum logic [1:0] {K_XFER, K_CFG, K_DRAIN, K_HOLD} step_kind_t;

  typedef struct {
    step_kind_t  kind;
    logic        op;
    logic [9:0]  idx;
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] yaw;
    logic [31:0] t;
    logic        last;
    logic [31:0] qt;
  } step_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] yaw;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vyaw;
    logic [9:0]  seg;
  } profile_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  tti_in_if  in_chan ();
  tti_out_if out_chan ();

  trajectory_time_interpolator_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Model state
  logic [31:0] traj_start;
  logic [31:0] tab_x [TABLE_DEPTH];
  logic [31:0] tab_y [TABLE_DEPTH];
  logic [15:0] tab_yaw [TABLE_DEPTH];
  logic [31:0] tab_t [TABLE_DEPTH];
  int          tab_len;

  step_t    plan_q[$];
  profile_t profile_q[$];
  int       mismatches;
  int       hold_req;
  int       burst_mode;

  initial begin
    clk = 1'b0;
  end
  always #6 clk = ~clk;

  function automatic longint wrap_heading(longint v);
    longint r;
    r = v % YAW_TURN;
    if (r < -YAW_HALF) r += YAW_TURN;
    if (r >= YAW_HALF) r -= YAW_TURN;
    return r;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic profile_t pose_at(int k);
    profile_t p;
    p = '0;
    p.x   = tab_x[k];
    p.y   = tab_y[k];
    p.yaw = 16'(wrap_heading(longint'($signed(tab_yaw[k]))));
    p.seg = 10'(k);
    return p;
  endfunction

  // Update the table, or compute the profile a query yields
  task automatic track_transaction(step_t s);
    profile_t p;
    longint   tau, num, dt, mu, x0, y0, a0, dx, dy, da;
    int       lo, hi, mid, i, last;
    if (s.op == OP_WRITE) begin
      tab_x[s.idx] = s.x;
      tab_y[s.idx] = s.y;
      tab_yaw[s.idx] = s.yaw;
      tab_t[s.idx] = s.t;
      if (s.last) tab_len = int'(s.idx) + 1;
    end else begin
      if (tab_len == 0) begin
        p = '0;
      end else begin
        last = tab_len - 1;
        tau = longint'({32'd0, s.qt}) - longint'({32'd0, traj_start});
        if (tau < 0) begin
          p = pose_at(0);
        end else if (tau >= longint'({32'd0, tab_t[last]})) begin
          p = pose_at(last);
        end else if (tau <= longint'({32'd0, tab_t[0]})) begin
          p = pose_at(0);
        end else begin
          lo = 1;
          hi = last;
          while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (longint'({32'd0, tab_t[mid]}) >= tau) hi = mid;
            else lo = mid + 1;
          end
          i = hi;
          num = tau - longint'({32'd0, tab_t[i-1]});
          if (num <= 0) begin
            p = pose_at(i - 1);
          end else begin
            dt = longint'({32'd0, tab_t[i]}) - longint'({32'd0, tab_t[i-1]});
            // num and dt are positive and below 2^32, so the shifted value stays positive
            mu = (num << MU_BITS) / dt;
            x0 = longint'($signed(tab_x[i-1]));
            y0 = longint'($signed(tab_y[i-1]));
            a0 = longint'($signed(tab_yaw[i-1]));
            dx = longint'($signed(tab_x[i])) - x0;
            dy = longint'($signed(tab_y[i])) - y0;
            da = wrap_heading(longint'($signed(tab_yaw[i])) - a0);
            p.x    = 32'(x0 + ((dx * mu) >>> MU_BITS));
            p.y    = 32'(y0 + ((dy * mu) >>> MU_BITS));
            p.yaw  = 16'(wrap_heading(a0 + ((da * mu) >>> MU_BITS)));
            p.vx   = clamp32(dx * 1000 / dt);
            p.vy   = clamp32(dy * 1000 / dt);
            p.vyaw = clamp32(da * 8000 / dt);
            p.seg  = 10'(i - 1);
          end
        end
      end
      profile_q.push_back(p);
    end
  endtask

  function automatic int draw_gap();
    if (burst_mode != 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  // Driver: present queued transactions, apply config writes at idle
  int    gap_cnt;
  int    settle_cnt;
  step_t head;
  logic  nxt_valid;
  logic  nxt_we;
  logic  in_acc;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      cfg_we <= 1'b0;
      gap_cnt = 0;
      settle_cnt = 0;
      hold_req = 0;
    end else begin
      in_acc = in_chan.valid && in_chan.ready;
      if (in_acc) begin
        head.kind = K_XFER;
        head.op = in_chan.op;
        head.idx = in_chan.entry_index;
        head.x = in_chan.entry_x;
        head.y = in_chan.entry_y;
        head.yaw = in_chan.entry_yaw;
        head.t = in_chan.entry_time;
        head.last = in_chan.last_entry;
        head.qt = in_chan.query_time;
        track_transaction(head);
      end
      nxt_valid = in_chan.valid && !in_acc;
      nxt_we = 1'b0;
      if (!nxt_valid) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
        end else if (plan_q.size() > 0) begin
          head = plan_q[0];
          case (head.kind)
            K_XFER: begin
              void'(plan_q.pop_front());
              in_chan.op <= head.op;
              in_chan.entry_index <= head.idx;
              in_chan.entry_x <= head.x;
              in_chan.entry_y <= head.y;
              in_chan.entry_yaw <= head.yaw;
              in_chan.entry_time <= head.t;
              in_chan.last_entry <= head.last;
              in_chan.query_time <= head.qt;
              nxt_valid = 1'b1;
              gap_cnt = draw_gap();
            end
            K_HOLD: begin
              void'(plan_q.pop_front());
              hold_req++;
            end
            default: begin
              // wait for the block to drain and settle before touching config
              if (profile_q.size() == 0 && !in_acc) settle_cnt++;
              else settle_cnt = 0;
              if (settle_cnt >= SETTLE) begin
                if (head.kind == K_CFG) begin
                  nxt_we = 1'b1;
                  cfg_wdata <= head.qt;
                  traj_start = head.qt;
                end
                void'(plan_q.pop_front());
                settle_cnt = 0;
              end
            end
          endcase
        end
      end
      in_chan.valid <= nxt_valid;
      cfg_we <= nxt_we;
    end
  end

  // Monitor: random backpressure, compare each result with the oldest expectation
  int       rdy_wait;
  int       hold_cnt;
  int       hold_seen;
  profile_t got, want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      rdy_wait = 0;
      hold_cnt = 0;
      hold_seen = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got = {out_chan.out_x, out_chan.out_y, out_chan.out_yaw, out_chan.out_vx,
               out_chan.out_vy, out_chan.out_vyaw, out_chan.segment_index};
        if (profile_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: %p", got);
        end else begin
          want = profile_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch x %h/%h y %h/%h yaw %h/%h", want.x, got.x,
                       want.y, got.y, want.yaw, got.yaw);
              $display("  vx %h/%h vy %h/%h vyaw %h/%h seg %0d/%0d", want.vx, got.vx,
                       want.vy, got.vy, want.vyaw, got.vyaw, want.seg, got.seg);
            end
          end
        end
        rdy_wait = draw_gap();
      end else if (hold_cnt > 0) begin
        hold_cnt--;
      end else if (rdy_wait > 0) begin
        rdy_wait--;
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_cnt = HOLD_LEN;
      end
      out_chan.ready <= (rdy_wait == 0 && hold_cnt == 0);
    end
  end

  // Watchdog: end the run if nothing moves for too long
  int idle_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)
        || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  int n_items;

  task automatic add_write(int idx, logic [31:0] x, logic [31:0] y, int yaw,
                           logic [31:0] t, logic last);
    step_t s;
    s = '{kind: K_XFER, op: OP_WRITE, idx: 10'(idx), x: x, y: y, yaw: 16'(yaw), t: t,
          last: last, qt: $urandom()};
    plan_q.push_back(s);
    n_items++;
  endtask

  task automatic add_query(logic [31:0] qt);
    step_t s;
    s = '{kind: K_XFER, op: OP_QUERY, idx: 10'($urandom()), x: $urandom(), y: $urandom(),
          yaw: 16'($urandom()), t: $urandom(), last: 1'($urandom()), qt: qt};
    plan_q.push_back(s);
    n_items++;
  endtask

  task automatic add_marker(step_kind_t k, logic [31:0] v);
    step_t s;
    s = '{kind: k, op: OP_WRITE, idx: '0, x: '0, y: '0, yaw: '0, t: '0, last: 1'b0, qt: v};
    plan_q.push_back(s);
  endtask

  function automatic int rand_yaw();
    return int'($urandom_range(0, 51471)) - 25736;
  endfunction

  // Build a table of n poses, then query it, mostly around its span, among random writes
  task automatic add_trajectory(logic [31:0] st, int n, int nq, bit hold_here);
    longint t, tend, span;
    int     mode;
    int     yaw;
    logic [31:0] x, y;
    add_marker(K_CFG, st);
    mode = $urandom_range(0, 3);
    t = (mode == 0) ? 0 : $urandom_range(0, 1000);
    x = $urandom();
    y = $urandom();
    yaw = rand_yaw();
    for (int k = 0; k < n; k++) begin
      add_write(k, x, y, yaw, 32'(t), k == n - 1);
      case (mode)
        0: t += $urandom_range(0, 3);
        1: t += $urandom_range(1, 60);
        default: t += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 1 << 24);
      endcase
      if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
      if ($urandom_range(0, 3) == 0) begin
        x = $urandom();
        y = $urandom();
        yaw = rand_yaw();
      end else begin
        x = x + 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
        y = y + 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
        yaw = int'(wrap_heading(yaw + $urandom_range(0, 6000) - 3000));
      end
    end
    tend = t;
    span = tend + 20;
    for (int q = 0; q < nq; q++) begin
      if (hold_here && q == 2) add_marker(K_HOLD, 0);
      case ($urandom_range(0, 9))
        0: add_query($urandom());
        1: add_write($urandom_range(n, 1023), $urandom(), $urandom(), rand_yaw(),
                     $urandom(), 1'b0);
        2: add_write($urandom_range(0, n - 1), $urandom(), $urandom(), rand_yaw(),
                     $urandom(), 1'b0);
        default: add_query(st + 32'(longint'($urandom_range(0, 32'(span))) - 10));
      endcase
    end
  endtask

  initial begin
    mismatches = 0;
    n_items = 0;
    burst_mode = 0;
    tab_len = 0;
    traj_start = '0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.op = OP_WRITE;
    in_chan.entry_index = '0;
    in_chan.entry_x = '0;
    in_chan.entry_y = '0;
    in_chan.entry_yaw = '0;
    in_chan.entry_time = '0;
    in_chan.last_entry = 1'b0;
    in_chan.query_time = '0;
    out_chan.ready = 1'b0;

    // Directed: empty table, extreme poses, saturating rates, edges of the span
    add_query(32'h0);
    add_query(32'hFFFF_FFFF);
    add_write(0, 32'h8000_0000, 32'h7FFF_FFFF, -25736, 32'd100, 1'b0);
    add_write(1, 32'h7FFF_FFFF, 32'h8000_0000, 25735, 32'd101, 1'b0);
    add_write(2, 32'h0000_0000, 32'hFFFF_FFFF, 0, 32'd101, 1'b0);
    add_write(3, 32'h0001_0000, 32'h0002_0000, 12000, 32'hFFFF_FFFF, 1'b1);
    add_query(32'd0);
    add_query(32'd50);
    add_query(32'd100);
    add_query(32'd101);
    add_query(32'd102);
    add_query(32'h8000_0000);
    add_query(32'hFFFF_FFFF);
    // unordered timestamps: entry 2 earlier than entry 1
    add_write(2, 32'h1234_5678, 32'h8765_4321, -100, 32'd50, 1'b0);
    add_query(32'd101);
    add_query(32'd3000);
    add_write(1023, 32'hFFFF_FFFF, 32'h0, 25735, 32'hFFFF_FFFF, 1'b0);
    add_marker(K_CFG, 32'hFFFF_FFFF);
    add_query(32'h0);
    add_query(32'hFFFF_FFFF);
    add_query(32'hFFFF_FFFE);
    add_marker(K_DRAIN, 0);

    // Random: mostly short tables, one long, varied start times
    add_trajectory(32'h0, 200, 40, 1'b1);
    for (int ph = 0; n_items < N_ITEMS; ph++) begin
      case (ph % 4)
        0: add_trajectory(32'h0, $urandom_range(2, 12), $urandom_range(15, 35), 1'b0);
        1: add_trajectory($urandom(), $urandom_range(2, 12), $urandom_range(15, 35), 1'b0);
        2: add_trajectory(32'hFFFF_FFF0 + $urandom_range(0, 15), $urandom_range(2, 6),
                          10, ph == 6);
        default: add_trajectory($urandom_range(0, 5000), $urandom_range(2, 16),
                                $urandom_range(15, 35), 1'b0);
      endcase
      if (ph % 5 == 3) add_marker(K_DRAIN, 0);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // toggle between back-to-back stretches and random gaps
    while (plan_q.size() > 0 || in_chan.valid) begin
      repeat (200) @(posedge clk);
      burst_mode = ($urandom_range(0, 2) == 0);
    end
    burst_mode = 0;
    while (profile_q.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatches == 0 && profile_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
